// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants and types of the 34-bit shift register stream cipher.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int REG_BITS   = 34;
    localparam int CNT_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    // feedback taps
    localparam int TAP_HIGH  = 33;
    localparam int TAP_MID_A = 14;
    localparam int TAP_MID_B = 13;

    // length of the opening phase that hands out the seed bits unchanged
    localparam logic [CNT_W-1:0] SEED_PHASE_LEN = CNT_W'(REG_BITS);

    // register index, taken from the 8-byte word address
    localparam logic REG_IDX_SEED = 1'b0;

    typedef logic [REG_BITS-1:0] t_seed;
    typedef logic [BYTE_W-1:0]   t_byte;

    // request from the datapath to the keystream generator
    typedef struct packed {
        logic step;
        logic first;
    } t_key_req;

endpackage

// ===== rtl/lsc_cfg.sv =====
// ----------------------------------------------------------------------------
// lsc_cfg
// APB register file: holds the seed register, write and read access.
// ----------------------------------------------------------------------------
module lsc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output lsc_pkg::t_seed                     o_seed
);

    lsc_pkg::t_seed r_seed;
    logic           reg_idx;
    logic           wr_en;

    // registers sit at 8-byte strides
    assign reg_idx = paddr[3];
    assign wr_en   = psel && penable && pwrite && (reg_idx == lsc_pkg::REG_IDX_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (wr_en) begin
            r_seed <= pwdata[lsc_pkg::REG_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == lsc_pkg::REG_IDX_SEED) begin
            prdata = lsc_pkg::APB_DATA_W'(r_seed);
        end
    end

    assign pready = 1'b1;
    assign o_seed = r_seed;

endmodule

// ===== rtl/lsc_keygen.sv =====
// ----------------------------------------------------------------------------
// lsc_keygen
// Keystream generator: shift register and opening-phase count, eight key
// bits per step, all eight bit steps unrolled into combinational logic.
// ----------------------------------------------------------------------------
module lsc_keygen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsc_pkg::t_key_req i_req,
    input  lsc_pkg::t_seed    i_seed,
    output lsc_pkg::t_byte    o_key
);

    lsc_pkg::t_seed               r_shift;
    logic [lsc_pkg::CNT_W-1:0]    r_used;
    lsc_pkg::t_seed               n_shift;
    logic [lsc_pkg::CNT_W-1:0]    n_used;
    lsc_pkg::t_byte               n_key;

    always_comb begin
        logic kbit;
        kbit    = 1'b0;
        n_shift = i_req.first ? i_seed : r_shift;
        n_used  = i_req.first ? '0 : r_used;
        n_key   = '0;
        for (int b = 0; b < lsc_pkg::BYTE_W; b++) begin
            if (n_used < lsc_pkg::SEED_PHASE_LEN) begin
                // opening phase: seed bits straight out, no shifting
                kbit   = n_shift[n_used];
                n_used = lsc_pkg::CNT_W'(n_used + 1'b1);
            end else begin
                kbit    = n_shift[lsc_pkg::TAP_HIGH] ^ n_shift[lsc_pkg::TAP_MID_A]
                        ^ n_shift[lsc_pkg::TAP_MID_B] ^ n_shift[0];
                n_shift = {n_shift[lsc_pkg::REG_BITS-2:0], kbit};
            end
            n_key[b] = kbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_used  <= '0;
        end else if (i_req.step) begin
            r_shift <= n_shift;
            r_used  <= n_used;
        end
    end

    assign o_key = n_key;

endmodule

// ===== rtl/lfsr_stream_cipher.sv =====
// a byte is taken into the input stage, and its result is registered in the result stage
// throughput: one byte per cycle while results are taken, the eight register steps of a byte are unrolled
// an input stage and a result stage part the two channels, so input stalls only
// when both stages hold data and the result is not taken
// reset (synchronous, active low) clears seed, shift register, count and valid flags
// ----------------------------------------------------------------------------
// lfsr_stream_cipher
// Byte stream cipher: each byte XORed with eight bits of a 34-bit LFSR
// keystream, seed written over APB.
// ----------------------------------------------------------------------------
module lfsr_stream_cipher (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_first_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_result_byte,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic              r_in_vld;
    lsc_pkg::t_byte    r_data;
    logic              r_first;
    logic              r_out_vld;
    lsc_pkg::t_byte    r_result;

    logic              advance;
    lsc_pkg::t_seed    seed;
    lsc_pkg::t_byte    key;
    lsc_pkg::t_key_req key_req;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    assign key_req.step  = advance;
    assign key_req.first = r_first;

    lsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (seed)
    );

    lsc_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (key_req),
        .i_seed  (seed),
        .o_key   (key)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_data  <= i_data_byte;
            r_first <= i_first_byte;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= r_data ^ key;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_result_byte = r_result;

endmodule

// ===== rtl/lsc_checker.sv =====
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks on the stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_result_byte,
    input logic       pready
);

    // a result waiting to be taken stays offered
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // and keeps its value
    `ASSERT_CLKD(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_result_byte), "result changed while stalled")

    // input side only stalls when the result stage is full and blocked
    `ASSERT_CLKD(a_in_stall, i_clk, i_rst_n, !o_in_ready |-> o_out_valid && !i_out_ready, "input stalled without output backpressure")

    // nothing is offered right after a reset cycle
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // register port never inserts wait states
    `ASSERT_CLKD(a_pready, i_clk, i_rst_n, pready, "pready low")

endmodule

bind lfsr_stream_cipher lsc_checker u_lsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_byte (o_result_byte),
    .pready        (pready)
);
